### rtl/core/tcw_pkg.sv
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int KEEP_END   = CELL_COUNT - COLUMNS - 1;

    // Widths
    localparam int ADDR_W    = $clog2(CELL_COUNT);
    localparam int ROW_W     = $clog2(ROWS + 1);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int CELL_W    = 16;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int REQ_W     = 2;
    localparam int IDX_W     = 11;
    localparam int POS_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W    = 4;

    typedef logic [STEP_W-1:0] step_t;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    // Memory operations
    localparam logic [2:0] MEM_NONE    = 3'd0;
    localparam logic [2:0] MEM_FILL    = 3'd1;
    localparam logic [2:0] MEM_COPY_RD = 3'd2;
    localparam logic [2:0] MEM_COPY_WR = 3'd3;
    localparam logic [2:0] MEM_PUT     = 3'd4;
    localparam logic [2:0] MEM_BLANK   = 3'd5;
    localparam logic [2:0] MEM_READ    = 3'd6;

    // Address counter operations
    localparam logic [1:0] ADDR_HOLD = 2'd0;
    localparam logic [1:0] ADDR_ZERO = 2'd1;
    localparam logic [1:0] ADDR_INC  = 2'd2;

    // Cursor operations
    localparam logic [2:0] CUR_HOLD    = 3'd0;
    localparam logic [2:0] CUR_HOME    = 3'd1;
    localparam logic [2:0] CUR_CR      = 3'd2;
    localparam logic [2:0] CUR_BS      = 3'd3;
    localparam logic [2:0] CUR_LF      = 3'd4;
    localparam logic [2:0] CUR_ADV     = 3'd5;
    localparam logic [2:0] CUR_LASTROW = 3'd6;

    // Branch kinds
    localparam logic [2:0] BR_NEXT   = 3'd0;
    localparam logic [2:0] BR_JUMP   = 3'd1;
    localparam logic [2:0] BR_LOOP   = 3'd2;
    localparam logic [2:0] BR_IDLE   = 3'd3;
    localparam logic [2:0] BR_SCROLL = 3'd4;
    localparam logic [2:0] BR_EMIT   = 3'd5;

    // Program steps
    localparam step_t STEP_INIT    = 4'd0;
    localparam step_t STEP_IDLE    = 4'd1;
    localparam step_t STEP_CR      = 4'd2;
    localparam step_t STEP_BS      = 4'd3;
    localparam step_t STEP_BS_WR   = 4'd4;
    localparam step_t STEP_LF      = 4'd5;
    localparam step_t STEP_CHR     = 4'd6;
    localparam step_t STEP_CHECK   = 4'd7;
    localparam step_t STEP_SCR_RD  = 4'd8;
    localparam step_t STEP_SCR_WR  = 4'd9;
    localparam step_t STEP_FILL    = 4'd10;
    localparam step_t STEP_DONE    = 4'd11;
    localparam step_t STEP_CLEAR   = 4'd12;
    localparam step_t STEP_READ    = 4'd13;
    localparam int    PROGRAM_LEN  = 14;

    typedef struct packed {
        logic [2:0] mem_op;
        logic       fill_zero;
        logic [1:0] addr_op;
        logic [2:0] cur_op;
        logic [2:0] br;
        logic       end_last;
        logic       emit;
        step_t      target;
    } ctrl_word_t;

    typedef struct packed {
        logic at_keep_end;
        logic at_last;
        logic row_over;
        logic out_hold;
    } dp_status_t;

    function automatic ctrl_word_t make_cw(
        logic [2:0] mem_op, logic fill_zero, logic [1:0] addr_op, logic [2:0] cur_op,
        logic [2:0] br, logic end_last, logic emit, step_t target);
        ctrl_word_t w;
        w.mem_op    = mem_op;
        w.fill_zero = fill_zero;
        w.addr_op   = addr_op;
        w.cur_op    = cur_op;
        w.br        = br;
        w.end_last  = end_last;
        w.emit      = emit;
        w.target    = target;
        return w;
    endfunction

    // Microprogram
    function automatic ctrl_word_t ucode_word(step_t step);
        ctrl_word_t w;
        case (step)
            STEP_INIT:   w = make_cw(MEM_FILL, 1'b1, ADDR_INC, CUR_HOLD, BR_LOOP,
                                     1'b1, 1'b0, STEP_INIT);
            STEP_IDLE:   w = make_cw(MEM_NONE, 1'b0, ADDR_ZERO, CUR_HOLD, BR_IDLE,
                                     1'b0, 1'b0, STEP_IDLE);
            STEP_CR:     w = make_cw(MEM_NONE, 1'b0, ADDR_HOLD, CUR_CR, BR_JUMP,
                                     1'b0, 1'b0, STEP_DONE);
            STEP_BS:     w = make_cw(MEM_NONE, 1'b0, ADDR_HOLD, CUR_BS, BR_NEXT,
                                     1'b0, 1'b0, STEP_BS_WR);
            STEP_BS_WR:  w = make_cw(MEM_BLANK, 1'b0, ADDR_HOLD, CUR_HOLD, BR_JUMP,
                                     1'b0, 1'b0, STEP_DONE);
            STEP_LF:     w = make_cw(MEM_NONE, 1'b0, ADDR_HOLD, CUR_LF, BR_JUMP,
                                     1'b0, 1'b0, STEP_CHECK);
            STEP_CHR:    w = make_cw(MEM_PUT, 1'b0, ADDR_HOLD, CUR_ADV, BR_NEXT,
                                     1'b0, 1'b0, STEP_CHECK);
            STEP_CHECK:  w = make_cw(MEM_NONE, 1'b0, ADDR_HOLD, CUR_HOLD, BR_SCROLL,
                                     1'b0, 1'b0, STEP_DONE);
            STEP_SCR_RD: w = make_cw(MEM_COPY_RD, 1'b0, ADDR_HOLD, CUR_HOLD, BR_NEXT,
                                     1'b0, 1'b0, STEP_SCR_WR);
            STEP_SCR_WR: w = make_cw(MEM_COPY_WR, 1'b0, ADDR_INC, CUR_LASTROW, BR_LOOP,
                                     1'b0, 1'b0, STEP_SCR_RD);
            STEP_FILL:   w = make_cw(MEM_FILL, 1'b0, ADDR_INC, CUR_HOLD, BR_LOOP,
                                     1'b1, 1'b0, STEP_FILL);
            STEP_DONE:   w = make_cw(MEM_NONE, 1'b0, ADDR_HOLD, CUR_HOLD, BR_EMIT,
                                     1'b0, 1'b1, STEP_IDLE);
            STEP_CLEAR:  w = make_cw(MEM_NONE, 1'b0, ADDR_HOLD, CUR_HOME, BR_JUMP,
                                     1'b0, 1'b0, STEP_FILL);
            STEP_READ:   w = make_cw(MEM_READ, 1'b0, ADDR_HOLD, CUR_HOLD, BR_JUMP,
                                     1'b0, 1'b0, STEP_DONE);
            default:     w = make_cw(MEM_NONE, 1'b0, ADDR_HOLD, CUR_HOLD, BR_JUMP,
                                     1'b0, 1'b0, STEP_IDLE);
        endcase
        return w;
    endfunction

    // Entry step for a new request
    function automatic step_t dispatch_target(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch);
        step_t s;
        case (req)
            REQ_PUT: begin
                if (ch == CH_CR) begin
                    s = STEP_CR;
                end else if (ch == CH_BS) begin
                    s = STEP_BS;
                end else if (ch == CH_LF) begin
                    s = STEP_LF;
                end else begin
                    s = STEP_CHR;
                end
            end
            REQ_CLEAR: s = STEP_CLEAR;
            REQ_READ:  s = STEP_READ;
            default:   s = STEP_DONE;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/tcw_sequencer.sv
module tcw_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [tcw_pkg::REQ_W-1:0]    req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  tcw_pkg::dp_status_t          status,
    output logic                         in_ready,
    output tcw_pkg::ctrl_word_t          ctrl
);

    tcw_pkg::step_t step_reg;
    tcw_pkg::step_t step_next;
    tcw_pkg::step_t step_inc;
    logic           at_end;

    // Fetch the control word of the current step
    assign ctrl     = tcw_pkg::ucode_word(step_reg);
    assign in_ready = (step_reg == tcw_pkg::STEP_IDLE);
    assign step_inc = step_reg + tcw_pkg::step_t'(1);
    assign at_end   = ctrl.end_last ? status.at_last : status.at_keep_end;

    // Pick the next step
    always_comb
    begin
        case (ctrl.br)
            tcw_pkg::BR_NEXT:   step_next = step_inc;
            tcw_pkg::BR_JUMP:   step_next = ctrl.target;
            tcw_pkg::BR_LOOP:   step_next = at_end ? step_inc : ctrl.target;
            tcw_pkg::BR_IDLE:   step_next = in_valid ?
                                    tcw_pkg::dispatch_target(req_type, char_code) : step_reg;
            tcw_pkg::BR_SCROLL: step_next = status.row_over ? step_inc : ctrl.target;
            tcw_pkg::BR_EMIT:   step_next = status.out_hold ? step_reg : ctrl.target;
            default:            step_next = tcw_pkg::STEP_IDLE;
        endcase
    end

    // Advance the step counter; start with the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tcw_pkg::STEP_INIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer ready right after taking a request");

    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < tcw_pkg::step_t'(tcw_pkg::PROGRAM_LEN))
        else $error("step counter left the program");

    a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && !status.out_hold) |=> (step_reg == tcw_pkg::STEP_IDLE))
        else $error("result sent without return to idle");
`endif

endmodule

### rtl/core/tcw_datapath.sv
module tcw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcw_pkg::ctrl_word_t           ctrl,
    input  logic                          accept,
    input  logic [tcw_pkg::REQ_W-1:0]     req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     cell_index,
    input  logic [tcw_pkg::COLOR_W-1:0]   fg_color,
    input  logic [tcw_pkg::COLOR_W-1:0]   bg_color,
    input  logic                          out_ready,
    output tcw_pkg::dp_status_t           status,
    output logic                          out_valid,
    output logic [tcw_pkg::POS_W-1:0]     cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]    cell_data
);

    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int CELL_W = tcw_pkg::CELL_W;

    logic [CELL_W-1:0] text_store_mem [tcw_pkg::CELL_COUNT];

    logic [tcw_pkg::REQ_W-1:0]  req_reg;
    logic [tcw_pkg::CHAR_W-1:0] char_reg;
    logic [tcw_pkg::IDX_W-1:0]  idx_reg;

    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    logic [CELL_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    logic [tcw_pkg::POS_W-1:0] cursor_position_reg;
    logic [CELL_W-1:0] cell_data_reg;

    logic [ADDR_W-1:0] cur_pos;
    logic [ADDR_W+tcw_pkg::POS_W-1:0] pos_ext;
    logic [ADDR_W+tcw_pkg::IDX_W-1:0] idx_ext;
    logic              idx_ok;
    logic [CELL_W-1:0] space_cell;
    logic [CELL_W-1:0] char_cell;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              re;
    logic [ADDR_W-1:0] rd_addr;
    logic              emit_fire;

    // Linear cursor address and cell words in the current colors
    assign cur_pos    = ADDR_W'(row_reg) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(col_reg);
    assign pos_ext    = {{tcw_pkg::POS_W{1'b0}}, cur_pos};
    assign idx_ext    = {{ADDR_W{1'b0}}, idx_reg};
    assign idx_ok     = (32'(idx_reg) < 32'(tcw_pkg::CELL_COUNT));
    assign space_cell = {bg_color, fg_color, tcw_pkg::CH_SPACE};
    assign char_cell  = {bg_color, fg_color, char_reg};

    assign status.at_keep_end = (addr_reg == ADDR_W'(tcw_pkg::KEEP_END));
    assign status.at_last     = (addr_reg == ADDR_W'(tcw_pkg::CELL_COUNT - 1));
    assign status.row_over    = (row_reg == ROW_W'(tcw_pkg::ROWS));
    assign status.out_hold    = out_valid_reg && !out_ready;

    assign emit_fire = ctrl.emit && !status.out_hold;

    // Hold the request fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            char_reg <= char_code;
            idx_reg  <= cell_index;
        end
    end

    // Cursor update
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        case (ctrl.cur_op)
            tcw_pkg::CUR_HOLD: ;
            tcw_pkg::CUR_HOME:
            begin
                row_next = '0;
                col_next = '0;
            end
            tcw_pkg::CUR_CR: col_next = '0;
            tcw_pkg::CUR_BS:
            begin
                if (col_reg != '0)
                begin
                    col_next = col_reg - COL_W'(1);
                end
            end
            tcw_pkg::CUR_LF:
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            tcw_pkg::CUR_ADV:
            begin
                if (col_reg == COL_W'(tcw_pkg::COLUMNS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            tcw_pkg::CUR_LASTROW: row_next = ROW_W'(tcw_pkg::ROWS - 1);
            default: ;
        endcase
    end

    // Address counter update
    always_comb
    begin
        case (ctrl.addr_op)
            tcw_pkg::ADDR_HOLD: addr_next = addr_reg;
            tcw_pkg::ADDR_ZERO: addr_next = '0;
            tcw_pkg::ADDR_INC:  addr_next = addr_reg + ADDR_W'(1);
            default:            addr_next = addr_reg;
        endcase
    end

    // Memory port selection
    always_comb
    begin
        we      = 1'b0;
        wr_addr = addr_reg;
        wr_data = space_cell;
        re      = 1'b0;
        rd_addr = addr_reg + ADDR_W'(tcw_pkg::COLUMNS);
        case (ctrl.mem_op)
            tcw_pkg::MEM_NONE: ;
            tcw_pkg::MEM_FILL:
            begin
                we      = 1'b1;
                wr_data = ctrl.fill_zero ? '0 : space_cell;
            end
            tcw_pkg::MEM_COPY_RD: re = 1'b1;
            tcw_pkg::MEM_COPY_WR:
            begin
                we      = 1'b1;
                wr_data = rd_data_reg;
            end
            tcw_pkg::MEM_PUT:
            begin
                we      = 1'b1;
                wr_addr = cur_pos;
                wr_data = char_cell;
            end
            tcw_pkg::MEM_BLANK:
            begin
                we      = 1'b1;
                wr_addr = cur_pos;
            end
            tcw_pkg::MEM_READ:
            begin
                re      = idx_ok;
                rd_addr = idx_ext[ADDR_W-1:0];
            end
            default: ;
        endcase
    end

    // Text store with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            text_store_mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= text_store_mem[rd_addr];
        end
    end

    // Cursor and address registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            addr_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            addr_reg <= addr_next;
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            cursor_position_reg <= pos_ext[tcw_pkg::POS_W-1:0];
            cell_data_reg       <= (req_reg == tcw_pkg::REQ_READ && idx_ok) ?
                                   rd_data_reg : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_position = cursor_position_reg;
    assign cell_data       = cell_data_reg;

`ifndef SYNTHESIS
    a_row_in_range_at_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> (row_reg < ROW_W'(tcw_pkg::ROWS)))
        else $error("cursor row past the screen when the result is sent");

    a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.mem_op == tcw_pkg::MEM_COPY_RD) |-> (addr_reg <= ADDR_W'(tcw_pkg::KEEP_END)))
        else $error("scroll copy beyond the kept rows");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(cell_data_reg)))
        else $error("pending result overwritten");
`endif

endmodule

### rtl/core/text_console_writer_top.sv
// Text console over an 80x25 store of 16-bit cells (attribute byte above the character).
// Each request returns one result with the linear cursor position; reads also return
// the cell. After reset the block sweeps the store to zero, one cell per clock, before
// it takes the first request; configuration writes are taken at any time. Each
// request runs as a sequence of steps from a microprogram that makes at most one
// access to the store per step: a clear blanks the store one cell per cycle, and a
// put that moves past the last row adds a scroll (read then write for each kept
// cell, then the bottom row blanked). A finished result waits in an output register
// while the next request is already taken.
module text_console_writer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tcw_pkg::REQ_W-1:0]       req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcw_pkg::IDX_W-1:0]       cell_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tcw_pkg::POS_W-1:0]       cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]      cell_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]     cfg_data
);

    logic [tcw_pkg::COLOR_W-1:0] fg_reg;
    logic [tcw_pkg::COLOR_W-1:0] bg_reg;
    tcw_pkg::ctrl_word_t         ctrl;
    tcw_pkg::dp_status_t         status;
    logic                        accept;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // Color registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tcw_pkg::FG_RESET;
            bg_reg <= tcw_pkg::BG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tcw_pkg::CFG_FOREGROUND: fg_reg <= cfg_data;
                tcw_pkg::CFG_BACKGROUND: bg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tcw_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .char_code (char_code),
        .status    (status),
        .in_ready  (in_ready),
        .ctrl      (ctrl)
    );

    tcw_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .accept          (accept),
        .req_type        (req_type),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .fg_color        (fg_reg),
        .bg_color        (bg_reg),
        .out_ready       (out_ready),
        .status          (status),
        .out_valid       (out_valid),
        .cursor_position (cursor_position),
        .cell_data       (cell_data)
    );

endmodule

### tb/text_console_writer_top_tb.sv
module text_console_writer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQ_W     = tcw_pkg::REQ_W;
    localparam int CHAR_W    = tcw_pkg::CHAR_W;
    localparam int IDX_W     = tcw_pkg::IDX_W;
    localparam int POS_W     = tcw_pkg::POS_W;
    localparam int CELL_W    = tcw_pkg::CELL_W;
    localparam int CFG_IDX_W = tcw_pkg::CFG_IDX_W;
    localparam int COLOR_W   = tcw_pkg::COLOR_W;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 30000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] data;
    } console_result_t;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SPARSE, SINK_TOGGLE} sink_mode_e;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type;
    logic [CHAR_W-1:0]    char_code;
    logic [IDX_W-1:0]     cell_index;
    logic                 out_valid;
    logic                 out_ready;
    logic [POS_W-1:0]     cursor_position;
    logic [CELL_W-1:0]    cell_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_data;

    // Predicted console: screen contents, cursor and colors
    logic [CELL_W-1:0]  screen [tcw_pkg::CELL_COUNT];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;

    console_result_t pending_results[$];
    int              fail_count;
    int              burst_left;
    bit              gaps_on;

    text_console_writer_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_position (cursor_position),
        .cell_data       (cell_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [CELL_W-1:0] colored_cell(logic [CHAR_W-1:0] ch);
        return {bg_color, fg_color, ch};
    endfunction

    // Apply one request to the predicted console and return the expected result
    function automatic console_result_t console_step(logic [REQ_W-1:0] req,
                                                     logic [CHAR_W-1:0] ch,
                                                     logic [IDX_W-1:0] idx);
        console_result_t r;
        r.data = '0;
        case (req)
            tcw_pkg::REQ_PUT:
            begin
                if (ch == tcw_pkg::CH_CR)
                begin
                    cur_col = 0;
                end
                else if (ch == tcw_pkg::CH_BS)
                begin
                    if (cur_col > 0)
                        cur_col--;
                    screen[cur_row * tcw_pkg::COLUMNS + cur_col] =
                        colored_cell(tcw_pkg::CH_SPACE);
                end
                else if (ch == tcw_pkg::CH_LF)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else
                begin
                    screen[cur_row * tcw_pkg::COLUMNS + cur_col] = colored_cell(ch);
                    cur_col++;
                    if (cur_col >= tcw_pkg::COLUMNS)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                // Scroll up one row and blank the bottom row
                if (cur_row >= tcw_pkg::ROWS)
                begin
                    for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
                        screen[i] = screen[i + tcw_pkg::COLUMNS];
                    for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS;
                         i < tcw_pkg::CELL_COUNT; i++)
                        screen[i] = colored_cell(tcw_pkg::CH_SPACE);
                    cur_row = tcw_pkg::ROWS - 1;
                end
            end
            tcw_pkg::REQ_CLEAR:
            begin
                for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
                    screen[i] = colored_cell(tcw_pkg::CH_SPACE);
                cur_row = 0;
                cur_col = 0;
            end
            tcw_pkg::REQ_READ:
            begin
                if (idx < tcw_pkg::CELL_COUNT)
                    r.data = screen[idx];
            end
            default:
            begin
            end
        endcase
        r.pos = POS_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
        return r;
    endfunction

    // Send one request; open a new burst, with a random gap when gaps are on, when the last one ran out
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 12) : 0;
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_type   = req;
        char_code  = ch;
        cell_index = idx;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(console_step(req, ch, idx));
        @(negedge clk);
    endtask

    // Hold off new requests until every expected result has come back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [COLOR_W-1:0] value);
        cfg_index = index;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == tcw_pkg::CFG_FOREGROUND)
            fg_color = value;
        else
            bg_color = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Reads of a zeroed store, out-of-range reads, unused request, reset colors
    task automatic test_reset_state();
        send_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
        send_request(tcw_pkg::REQ_READ, 8'hFF, IDX_W'(tcw_pkg::CELL_COUNT - 1));
        send_request(tcw_pkg::REQ_READ, 8'h00, IDX_W'(tcw_pkg::CELL_COUNT));
        send_request(tcw_pkg::REQ_READ, 8'h00, 11'h7FF);
        send_request(REQ_UNUSED, 8'hFF, 11'h7FF);
        send_request(tcw_pkg::REQ_PUT, "A", 11'd0);
        send_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
    endtask

    // Backspace in and at column zero, character extremes, carriage return, line feed
    task automatic test_control_chars();
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BS, 11'd0);
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BS, 11'd0);
        send_request(tcw_pkg::REQ_PUT, 8'h00, 11'd0);
        send_request(tcw_pkg::REQ_PUT, 8'hFF, 11'd0);
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_CR, 11'd0);
        send_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
        send_request(tcw_pkg::REQ_READ, 8'h00, 11'd1);
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_LF, 11'd0);
        send_request(tcw_pkg::REQ_PUT, "x", 11'd0);
        send_request(tcw_pkg::REQ_READ, 8'h00, IDX_W'(tcw_pkg::COLUMNS));
    endtask

    // Clear with the brightest colors, then backspace at home
    task automatic test_clear_screen();
        wait_drained();
        write_register(tcw_pkg::CFG_FOREGROUND, 4'hF);
        write_register(tcw_pkg::CFG_BACKGROUND, 4'hF);
        send_request(tcw_pkg::REQ_CLEAR, 8'h00, 11'd0);
        send_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
        send_request(tcw_pkg::REQ_READ, 8'h00, IDX_W'(tcw_pkg::CELL_COUNT - 1));
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BS, 11'd0);
        send_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
    endtask

    // Random text with line breaks, edits, reads and clears under one color setting
    task automatic test_random_text(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                                    input int n_items, input bit with_gaps);
        int sent;
        int pick;
        int run_len;
        logic [IDX_W-1:0] idx;
        wait_drained();
        write_register(tcw_pkg::CFG_FOREGROUND, fg);
        write_register(tcw_pkg::CFG_BACKGROUND, bg);
        gaps_on = with_gaps;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            idx  = IDX_W'($urandom);
            if (pick < 1)
            begin
                // a long line of printable text that can wrap
                run_len = $urandom_range(20, 100);
                repeat (run_len)
                    send_request(tcw_pkg::REQ_PUT, CHAR_W'($urandom_range(32, 126)),
                                 IDX_W'($urandom));
                sent += run_len;
            end
            else
            begin
                if (pick < 50)
                    send_request(tcw_pkg::REQ_PUT, CHAR_W'($urandom_range(0, 255)), idx);
                else if (pick < 60)
                    send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_LF, idx);
                else if (pick < 66)
                    send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_CR, idx);
                else if (pick < 74)
                    send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BS, idx);
                else if (pick < 84)
                    send_request(tcw_pkg::REQ_READ, CHAR_W'($urandom),
                                 IDX_W'((cur_row * tcw_pkg::COLUMNS + cur_col
                                         + tcw_pkg::CELL_COUNT - $urandom_range(0, 3))
                                        % tcw_pkg::CELL_COUNT));
                else if (pick < 93)
                    send_request(tcw_pkg::REQ_READ, CHAR_W'($urandom), idx);
                else if (pick < 95)
                    send_request(tcw_pkg::REQ_CLEAR, CHAR_W'($urandom), idx);
                else if (pick < 97)
                    send_request(REQ_UNUSED, CHAR_W'($urandom), idx);
                else
                begin
                    // pause until the pipeline is empty, then go on
                    wait_drained();
                    send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_CR, idx);
                end
                sent++;
            end
        end
    endtask

    // Result sink: stall on a pattern whose mode is picked anew at random
    initial
    begin : result_sink
        sink_mode_e mode;
        int         mode_left;
        out_ready = 1'b0;
        mode      = SINK_OPEN;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = sink_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:   out_ready = 1'b1;
                SINK_RANDOM: out_ready = 1'($urandom_range(0, 1));
                SINK_SPARSE: out_ready = ($urandom_range(0, 7) == 0);
                default:     out_ready = ~out_ready;
            endcase
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        console_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: cursor_position %0d cell_data %h",
                       cursor_position, cell_data);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (cursor_position !== want.pos)
                begin
                    $error("cursor_position expected %0d actual %0d", want.pos, cursor_position);
                    fail_count++;
                end
                if (cell_data !== want.data)
                begin
                    $error("cell_data expected %h actual %h", want.data, cell_data);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("text_console_writer_top_tb: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = tcw_pkg::REQ_PUT;
        char_code  = '0;
        cell_index = '0;
        cfg_valid  = 1'b0;
        cfg_index  = tcw_pkg::CFG_FOREGROUND;
        cfg_data   = '0;
        fail_count = 0;
        burst_left = 0;
        gaps_on    = 1'b1;
        for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
            screen[i] = '0;
        cur_row  = 0;
        cur_col  = 0;
        fg_color = tcw_pkg::FG_RESET;
        bg_color = tcw_pkg::BG_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_control_chars();
        test_clear_screen();
        test_random_text(4'hF, 4'hF, 200, 1'b1);
        test_random_text(4'h0, 4'h0, 200, 1'b0);
        test_random_text(COLOR_W'($urandom), COLOR_W'($urandom), 200, 1'b1);
        test_random_text(tcw_pkg::FG_RESET, tcw_pkg::BG_RESET, 200, 1'b1);
        test_random_text(COLOR_W'($urandom), COLOR_W'($urandom), 200, 1'b1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("text_console_writer_top_tb: PASS");
        else
            $display("text_console_writer_top_tb: FAIL");
        $finish;
    end

endmodule
